@@ hdl/linear_segment_interpolator_3d_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the linear segment interpolator
// Clocked checks with an active-low asynchronous reset; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef LINEAR_SEGMENT_INTERPOLATOR_3D_TOP_ASSERT_SVH
`define LINEAR_SEGMENT_INTERPOLATOR_3D_TOP_ASSERT_SVH

`ifndef SYNTH
`define LSI_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("lsi assertion failed");
`define LSI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lsi implication failed");
`else
`define LSI_ASSERT(lbl, clk, rst_n, prop)
`define LSI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/lsi_pkg.sv @@
// ----------------------------------------------------------------------------
// lsi_pkg
// Shared types and constants of the linear segment interpolator.
// ----------------------------------------------------------------------------
package lsi_pkg;

  localparam int COORD_W   = 24;
  localparam int DELTA_W   = 25;
  localparam int SQ_W      = 48;
  localparam int RAD_W     = 50;
  localparam int ROOT_W    = 25;
  localparam int REM_W     = ROOT_W + 2;
  localparam int DIV_NUM_W = 41;
  localparam int DIV_DEN_W = 30;
  localparam int TOTAL_W   = 16;
  localparam int INDEX_W   = 17;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;
  localparam int FEED_W    = 20;
  localparam int IVL_W     = 10;
  localparam int MINL_W    = 16;
  localparam int CNT_W     = 5;

  localparam logic [9:0] MS_PER_S = 10'd1000;

  localparam logic [FEED_W-1:0] FEED_RST = 20'd25600;
  localparam logic [IVL_W-1:0]  IVL_RST  = 10'd10;
  localparam logic [MINL_W-1:0] MINL_RST = 16'd26;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_FEED_SPEED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_MS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH  = 2'd2;

  localparam logic [CNT_W-1:0] SQUARE_LAST = 5'd3;
  localparam logic [CNT_W-1:0] SQRT_LAST   = 5'd24;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SQRT_INIT,
    ST_SQRT,
    ST_LEN_CHK,
    ST_RATE,
    ST_LEN_WAIT,
    ST_ADV_MUL,
    ST_PT_DIV,
    ST_PT_WAIT,
    ST_PT_OUT
  } lsi_state_e;

  typedef struct packed {
    logic             capture;
    logic             sq_step;
    logic [1:0]       sq_axis;
    logic             sqrt_init;
    logic             sqrt_step;
    logic             rate_calc;
    logic             commit_short;
    logic             commit_zero;
    logic             commit_len;
    logic             div_start;
    logic             div_len;
    logic             adv_mul;
    logic             out_load;
  } lsi_cmd_t;

  typedef struct packed {
    logic short_seg;
    logic rate_zero;
    logic div_busy;
    logic div_done;
    logic seg_active;
    logic out_free;
  } lsi_sts_t;

endpackage

@@ hdl/linear_segment_interpolator_3d_top.sv @@
// ----------------------------------------------------------------------------
// linear_segment_interpolator_3d_top
// Cuts a straight 3D move into evenly spaced points, one point per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o): operation_i = 0 loads a segment
//   (start, end, tool flag) and produces no output transfer; operation_i = 1
//   requests the next point, which leaves on the output channel
//   (out_valid_o/out_ready_i) with tool, last and saturation flags.
//   Configuration (feed speed, interval, minimum length) is written through
//   cfg_we_i/cfg_idx_i/cfg_data_i while the block is idle.
//   A load runs 4 square steps, root setup, 25 square-root steps, the
//   length check, the rate product and a 41-bit bit-serial division; a
//   short segment commits at the length check, a zero rate after the rate
//   product. A point request on a pending segment runs the multiply, the
//   division in three lanes and the output load; the next item can be taken
//   in the cycle after the output load. Both use the 41-bit restoring divider.
//   One item is in work at a time; in_ready_o is high only between items.
//   Reset clears the segment state (no segment pending) and loads the
//   register defaults. When the receiver stalls, the finished point holds in
//   the output register, the next item is still taken, and its point waits
//   until the register frees.
// ----------------------------------------------------------------------------
module linear_segment_interpolator_3d_top import lsi_pkg::*; #(
  parameter int MAX_POINTS      = 65535,
  parameter int MAX_SPEED_LIMIT = 1048575
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0]           cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       operation_i,
  input  logic signed [COORD_W-1:0]  start_x_i,
  input  logic signed [COORD_W-1:0]  start_y_i,
  input  logic signed [COORD_W-1:0]  start_z_i,
  input  logic signed [COORD_W-1:0]  end_x_i,
  input  logic signed [COORD_W-1:0]  end_y_i,
  input  logic signed [COORD_W-1:0]  end_z_i,
  input  logic                       tool_on_in_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [COORD_W-1:0]  point_x_o,
  output logic signed [COORD_W-1:0]  point_y_o,
  output logic signed [COORD_W-1:0]  point_z_o,
  output logic                       tool_on_out_o,
  output logic                       last_point_o,
  output logic                       count_saturated_o,
  output logic                       no_segment_o
);

  // command and status between sequencer and datapath
  lsi_cmd_t cmd;
  lsi_sts_t sts;

  lsi_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .operation_i,
    .in_ready_o,
    .sts_i (sts),
    .cmd_o (cmd)
  );

  lsi_dp #(
    .MAX_POINTS      (MAX_POINTS),
    .MAX_SPEED_LIMIT (MAX_SPEED_LIMIT)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .start_x_i,
    .start_y_i,
    .start_z_i,
    .end_x_i,
    .end_y_i,
    .end_z_i,
    .tool_on_in_i,
    .out_ready_i,
    .out_valid_o,
    .point_x_o,
    .point_y_o,
    .point_z_o,
    .tool_on_out_o,
    .last_point_o,
    .count_saturated_o,
    .no_segment_o,
    .cmd_i (cmd),
    .sts_o (sts)
  );

endmodule

@@ hdl/lsi_div.sv @@
// ----------------------------------------------------------------------------
// lsi_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lsi_div import lsi_pkg::*; #(
  parameter int NUM_W = 41,
  parameter int DEN_W = 30
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quot_o,
  output logic             busy_o,
  output logic             done_o
);

  localparam int CW = $clog2(NUM_W + 1);
  localparam logic [CW-1:0] LAST = CW'(NUM_W - 1);

  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] rem_q, rem_d, den_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q;
  logic [DEN_W:0]   shifted, diff;
  logic             fits;

  assign shifted = {rem_q, num_q[NUM_W-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign fits    = shifted >= {1'b0, den_q};

  always_comb begin
    rem_d = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    num_d = {num_q[NUM_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign quot_o = num_q;
  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

@@ hdl/lsi_ctrl.sv @@
// ----------------------------------------------------------------------------
// lsi_ctrl
// Sequencer for segment load and point advance.
// ----------------------------------------------------------------------------
`include "linear_segment_interpolator_3d_top_assert.svh"

module lsi_ctrl import lsi_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     operation_i,
  output logic     in_ready_o,
  input  lsi_sts_t sts_i,
  output lsi_cmd_t cmd_o
);

  lsi_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [5:0]       act;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          cnt_d = '0;
          if (operation_i == OP_LOAD) begin
            state_d = ST_SQUARE;
          end else if (sts_i.seg_active) begin
            state_d = ST_ADV_MUL;
          end else begin
            state_d = ST_PT_OUT;
          end
        end
      end
      ST_SQUARE: begin
        cmd_o.sq_step = 1'b1;
        cmd_o.sq_axis = cnt_q[1:0];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == SQUARE_LAST) begin
          state_d = ST_SQRT_INIT;
        end
      end
      ST_SQRT_INIT: begin
        cmd_o.sqrt_init = 1'b1;
        cnt_d = '0;
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == SQRT_LAST) begin
          state_d = ST_LEN_CHK;
        end
      end
      ST_LEN_CHK: begin
        if (sts_i.short_seg) begin
          cmd_o.commit_short = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cmd_o.rate_calc = 1'b1;
          state_d = ST_RATE;
        end
      end
      ST_RATE: begin
        if (sts_i.rate_zero) begin
          cmd_o.commit_zero = 1'b1;
          state_d = ST_IDLE;
        end else if (!sts_i.div_busy) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_len   = 1'b1;
          state_d = ST_LEN_WAIT;
        end
      end
      ST_LEN_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.commit_len = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_ADV_MUL: begin
        cmd_o.adv_mul = 1'b1;
        state_d = ST_PT_DIV;
      end
      ST_PT_DIV: begin
        if (!sts_i.div_busy) begin
          cmd_o.div_start = 1'b1;
          state_d = ST_PT_WAIT;
        end
      end
      ST_PT_WAIT: begin
        if (sts_i.div_done) begin
          state_d = ST_PT_OUT;
        end
      end
      ST_PT_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign act = {cmd_o.capture, cmd_o.sqrt_step, cmd_o.div_start, cmd_o.out_load,
                cmd_o.commit_len, cmd_o.commit_short};

  `LSI_ASSERT(a_one_action, clk_i, rst_ni, $onehot0(act))
  `LSI_ASSERT_IMPL(a_out_slot, clk_i, rst_ni, cmd_o.out_load, sts_i.out_free)
  `LSI_ASSERT_IMPL(a_div_idle, clk_i, rst_ni, cmd_o.div_start, !sts_i.div_busy)

endmodule

@@ hdl/lsi_dp.sv @@
// ----------------------------------------------------------------------------
// lsi_dp
// Datapath: configuration, length, point count, segment state, output.
// ----------------------------------------------------------------------------
module lsi_dp import lsi_pkg::*; #(
  parameter int MAX_POINTS      = 65535,
  parameter int MAX_SPEED_LIMIT = 1048575
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0]           cfg_data_i,
  input  logic signed [COORD_W-1:0]  start_x_i,
  input  logic signed [COORD_W-1:0]  start_y_i,
  input  logic signed [COORD_W-1:0]  start_z_i,
  input  logic signed [COORD_W-1:0]  end_x_i,
  input  logic signed [COORD_W-1:0]  end_y_i,
  input  logic signed [COORD_W-1:0]  end_z_i,
  input  logic                       tool_on_in_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic signed [COORD_W-1:0]  point_x_o,
  output logic signed [COORD_W-1:0]  point_y_o,
  output logic signed [COORD_W-1:0]  point_z_o,
  output logic                       tool_on_out_o,
  output logic                       last_point_o,
  output logic                       count_saturated_o,
  output logic                       no_segment_o,
  input  lsi_cmd_t                   cmd_i,
  output lsi_sts_t                   sts_o
);

  localparam logic [TOTAL_W-1:0] MAXP = TOTAL_W'(MAX_POINTS);
  localparam logic [FEED_W-1:0]  MAXS = FEED_W'(MAX_SPEED_LIMIT);

  // configuration
  logic [FEED_W-1:0] feed_q;
  logic [IVL_W-1:0]  ivl_q;
  logic [MINL_W-1:0] minl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      feed_q <= FEED_RST;
      ivl_q  <= IVL_RST;
      minl_q <= MINL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FEED_SPEED:  feed_q <= (cfg_data_i > MAXS) ? MAXS : cfg_data_i;
        REG_INTERVAL_MS: ivl_q  <= cfg_data_i[IVL_W-1:0];
        REG_MIN_LENGTH:  minl_q <= cfg_data_i[MINL_W-1:0];
        default: ;
      endcase
    end
  end

  // captured load item
  logic signed [COORD_W-1:0] s_q [3];
  logic signed [COORD_W-1:0] e_q [3];
  logic                      tool_w_q;
  logic signed [DELTA_W-1:0] wd   [3];
  logic [COORD_W-1:0]        wabs [3];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      s_q[0]   <= start_x_i;
      s_q[1]   <= start_y_i;
      s_q[2]   <= start_z_i;
      e_q[0]   <= end_x_i;
      e_q[1]   <= end_y_i;
      e_q[2]   <= end_z_i;
      tool_w_q <= tool_on_in_i;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_delta
    logic signed [DELTA_W-1:0] neg_d;
    assign wd[k]   = {e_q[k][COORD_W-1], e_q[k]} - {s_q[k][COORD_W-1], s_q[k]};
    assign neg_d   = -wd[k];
    assign wabs[k] = wd[k][DELTA_W-1] ? neg_d[COORD_W-1:0] : wd[k][COORD_W-1:0];
  end

  // sum of squares, one axis per cycle
  logic [SQ_W-1:0]    sq_q;
  logic [RAD_W-1:0]   acc_q;
  logic [COORD_W-1:0] sq_in;

  always_comb begin
    case (cmd_i.sq_axis)
      2'd0:    sq_in = wabs[0];
      2'd1:    sq_in = wabs[1];
      2'd2:    sq_in = wabs[2];
      default: sq_in = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sq_q  <= '0;
      acc_q <= '0;
    end else if (cmd_i.sq_step) begin
      sq_q  <= sq_in * sq_in;
      acc_q <= acc_q + {2'b00, sq_q};
    end
  end

  // integer square root, one root bit per cycle
  logic [RAD_W-1:0]  rad_q;
  logic [REM_W-1:0]  srem_q, srem_sh, strial;
  logic [ROOT_W-1:0] root_q;
  logic              sfit;

  assign srem_sh = {srem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign strial  = {root_q, 2'b01};
  assign sfit    = srem_sh >= strial;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_init) begin
      rad_q  <= acc_q + {2'b00, sq_q};
      srem_q <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      srem_q <= sfit ? srem_sh - strial : srem_sh;
      root_q <= {root_q[ROOT_W-2:0], sfit};
    end
  end

  // point rate terms
  logic [DIV_DEN_W-1:0] rate_q;
  logic [DIV_NUM_W-1:0] lenk_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rate_calc) begin
      rate_q <= feed_q * ivl_q;
      lenk_q <= DIV_NUM_W'(root_q) * DIV_NUM_W'(MS_PER_S);
    end
  end

  // segment state
  logic signed [COORD_W-1:0] seg_start_q [3];
  logic signed [DELTA_W-1:0] seg_delta_q [3];
  logic [TOTAL_W-1:0]        total_q;
  logic [INDEX_W-1:0]        index_q;
  logic                      seg_tool_q, seg_active_q, seg_sat_q;
  logic [DIV_NUM_W-1:0]      quot [3];
  logic                      last_pt;

  assign last_pt = index_q >= {1'b0, total_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        seg_start_q[k] <= '0;
        seg_delta_q[k] <= '0;
      end
      total_q      <= '0;
      index_q      <= '0;
      seg_tool_q   <= 1'b0;
      seg_active_q <= 1'b0;
      seg_sat_q    <= 1'b0;
    end else if (cmd_i.commit_short) begin
      for (int k = 0; k < 3; k++) begin
        seg_start_q[k] <= e_q[k];
        seg_delta_q[k] <= '0;
      end
      total_q      <= '0;
      index_q      <= '0;
      seg_tool_q   <= tool_w_q;
      seg_active_q <= 1'b1;
      seg_sat_q    <= 1'b0;
    end else if (cmd_i.commit_zero || cmd_i.commit_len) begin
      for (int k = 0; k < 3; k++) begin
        seg_start_q[k] <= s_q[k];
        seg_delta_q[k] <= wd[k];
      end
      index_q      <= '0;
      seg_tool_q   <= tool_w_q;
      seg_active_q <= 1'b1;
      if (cmd_i.commit_zero || quot[0] >= DIV_NUM_W'(MAXP)) begin
        total_q   <= MAXP;
        seg_sat_q <= 1'b1;
      end else begin
        seg_sat_q <= 1'b0;
        total_q   <= (quot[0] == '0) ? TOTAL_W'(2) : quot[0][TOTAL_W-1:0] + 1'b1;
      end
    end else if (cmd_i.out_load && seg_active_q) begin
      if (last_pt) begin
        seg_active_q <= 1'b0;
        index_q      <= '0;
      end else begin
        index_q <= index_q + 1'b1;
      end
    end
  end

  // offset magnitudes for the next point
  logic [DIV_NUM_W-1:0] mag_q [3];
  logic                 neg_q [3];

  for (genvar k = 0; k < 3; k++) begin : g_mag
    logic signed [DELTA_W-1:0] nd;
    logic [COORD_W-1:0]        ad;
    logic [DIV_NUM_W-1:0]      prod;
    assign nd   = -seg_delta_q[k];
    assign ad   = seg_delta_q[k][DELTA_W-1] ? nd[COORD_W-1:0] : seg_delta_q[k][COORD_W-1:0];
    assign prod = {{(DIV_NUM_W-COORD_W){1'b0}}, ad} * {{(DIV_NUM_W-INDEX_W){1'b0}}, index_q};
    always_ff @(posedge clk_i) begin
      if (cmd_i.adv_mul) begin
        mag_q[k] <= prod + DIV_NUM_W'(total_q[TOTAL_W-1:1]);
        neg_q[k] <= seg_delta_q[k][DELTA_W-1];
      end
    end
  end

  // three divider lanes; lane 0 also divides the scaled length
  logic [DIV_NUM_W-1:0] num0;
  logic [DIV_DEN_W-1:0] den_pt, den0;
  logic                 busy [3];
  logic                 done [3];

  assign num0   = cmd_i.div_len ? lenk_q : mag_q[0];
  assign den_pt = {{(DIV_DEN_W-TOTAL_W){1'b0}}, total_q};
  assign den0   = cmd_i.div_len ? rate_q : den_pt;

  lsi_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div0 (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .num_i(num0), .den_i(den0),
    .quot_o(quot[0]), .busy_o(busy[0]), .done_o(done[0])
  );
  lsi_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div1 (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .num_i(mag_q[1]), .den_i(den_pt),
    .quot_o(quot[1]), .busy_o(busy[1]), .done_o(done[1])
  );
  lsi_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div2 (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .num_i(mag_q[2]), .den_i(den_pt),
    .quot_o(quot[2]), .busy_o(busy[2]), .done_o(done[2])
  );

  // output register
  logic                      ov_q;
  logic signed [COORD_W-1:0] px_q [3];
  logic                      tool_q, last_q, sat_q, nos_q;
  logic signed [COORD_W-1:0] pt   [3];

  for (genvar k = 0; k < 3; k++) begin : g_pt
    logic [DELTA_W-1:0] off, soff, sum;
    assign off  = (total_q == '0) ? '0 : quot[k][DELTA_W-1:0];
    assign soff = neg_q[k] ? -off : off;
    assign sum  = {seg_start_q[k][COORD_W-1], seg_start_q[k]} + soff;
    assign pt[k] = sum[COORD_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      for (int k = 0; k < 3; k++) begin
        px_q[k] <= seg_active_q ? pt[k] : '0;
      end
      tool_q <= seg_active_q & seg_tool_q;
      last_q <= seg_active_q & last_pt;
      sat_q  <= seg_active_q & seg_sat_q;
      nos_q  <= !seg_active_q;
    end
  end

  assign out_valid_o       = ov_q;
  assign point_x_o         = px_q[0];
  assign point_y_o         = px_q[1];
  assign point_z_o         = px_q[2];
  assign tool_on_out_o     = tool_q;
  assign last_point_o      = last_q;
  assign count_saturated_o = sat_q;
  assign no_segment_o      = nos_q;

  assign sts_o.short_seg  = root_q < {{(ROOT_W-MINL_W){1'b0}}, minl_q};
  assign sts_o.rate_zero  = rate_q == '0;
  assign sts_o.div_busy   = busy[0] | busy[1] | busy[2];
  assign sts_o.div_done   = done[0] & done[1] & done[2];
  assign sts_o.seg_active = seg_active_q;
  assign sts_o.out_free   = !ov_q || out_ready_i;

endmodule

@@ dv/linear_segment_interpolator_3d_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_segment_interpolator_3d_top_tb
// Self-checking bench: a table of directed segments, then random segment
// loads and point requests under several register settings and idle mixes.
// Every point transfer is compared with an in-bench fixed-point predictor
// ----------------------------------------------------------------------------
module linear_segment_interpolator_3d_top_tb;
  import lsi_pkg::*;

  localparam longint CYCLE_LIMIT = 2000000;
  localparam int     SETTLE      = 120;     // covers the tail of a load
  localparam int     PHASE_ITEMS = 350;
  localparam longint SPEED_MAX   = 1048575;
  localparam longint POINTS_MAX  = 65535;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      tool;
    logic                      last;
    logic                      sat;
    logic                      noseg;
  } point_t;

  typedef struct packed {
    logic                      op;
    logic signed [COORD_W-1:0] sx, sy, sz, ex, ey, ez;
    logic                      tool;
    logic                      typed;
    point_t                    want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready_o;
  logic operation = OP_LOAD;
  logic signed [COORD_W-1:0] sx = '0, sy = '0, sz = '0, ex = '0, ey = '0, ez = '0;
  logic tool_in = 1'b0;
  logic out_valid_o;
  logic out_ready = 1'b0;
  logic signed [COORD_W-1:0] px, py, pz;
  logic tool_out, last_out, sat_out, noseg_out;

  // typed expectation travels with the payload of the directed rows
  logic   has_typed = 1'b0;
  point_t typed_pt = '0;

  int     send_idle = 0;
  int     recv_idle = 0;
  int     hold_cycles = 0;
  longint cycles = 0;
  int     errs = 0;
  int     sent = 0;
  point_t point_q[$];
  row_t   plan[$];

  // predictor copy of registers and segment state
  longint feed = 25600, ivl = 10, minl = 26;
  longint seg_s[3], seg_d[3];
  longint total = 0, idx = 0;
  bit     seg_tool = 0, seg_on = 0, seg_sat = 0;

  linear_segment_interpolator_3d_top u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation),
    .start_x_i        (sx),
    .start_y_i        (sy),
    .start_z_i        (sz),
    .end_x_i          (ex),
    .end_y_i          (ey),
    .end_z_i          (ez),
    .tool_on_in_i     (tool_in),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .point_x_o        (px),
    .point_y_o        (py),
    .point_z_o        (pz),
    .tool_on_out_o    (tool_out),
    .last_point_o     (last_out),
    .count_saturated_o(sat_out),
    .no_segment_o     (noseg_out)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Floor square root, one result bit per step from the top.
  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned r, t;
    r = 0;
    for (int b = 25; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  // Latch a new segment into the predictor; a load never makes a point.
  function automatic void take_segment(row_t r);
    longint s[3], e[3];
    longint unsigned sq, len, div, n;
    s[0] = r.sx; s[1] = r.sy; s[2] = r.sz;
    e[0] = r.ex; e[1] = r.ey; e[2] = r.ez;
    sq = 0;
    for (int k = 0; k < 3; k++) sq += (e[k] - s[k]) * (e[k] - s[k]);
    len = floor_root(sq);
    seg_tool = r.tool;
    seg_on = 1;
    seg_sat = 0;
    idx = 0;
    if (len < minl) begin
      // short move: the end point alone
      for (int k = 0; k < 3; k++) begin
        seg_s[k] = e[k];
        seg_d[k] = 0;
      end
      total = 0;
      return;
    end
    for (int k = 0; k < 3; k++) begin
      seg_s[k] = s[k];
      seg_d[k] = e[k] - s[k];
    end
    div = feed * ivl;
    if (div == 0) begin
      n = POINTS_MAX;
      seg_sat = 1;
    end else begin
      n = len * 1000 / div + 1;
      if (n > POINTS_MAX) begin
        n = POINTS_MAX;
        seg_sat = 1;
      end
      if (n < 2) n = 2;
    end
    total = n;
  endfunction

  // Next point of the pending segment, rounded half away from zero.
  function automatic point_t next_point();
    point_t p;
    longint c[3];
    longint unsigned mag, q;
    p = '0;
    if (!seg_on) begin
      p.noseg = 1'b1;
      return p;
    end
    for (int k = 0; k < 3; k++) begin
      c[k] = seg_s[k];
      if (total != 0) begin
        mag = (seg_d[k] < 0 ? -seg_d[k] : seg_d[k]) * idx;
        q = (mag + total / 2) / total;
        c[k] = seg_d[k] < 0 ? c[k] - longint'(q) : c[k] + longint'(q);
      end
    end
    p.x = c[0][COORD_W-1:0];
    p.y = c[1][COORD_W-1:0];
    p.z = c[2][COORD_W-1:0];
    p.tool = seg_tool;
    p.last = (idx >= total);
    p.sat = seg_sat;
    if (idx >= total) begin
      seg_on = 0;
      idx = 0;
    end else begin
      idx++;
    end
    return p;
  endfunction

  function automatic row_t row(logic op, int ax, int ay, int az, int bx, int by, int bz,
                               logic tl, logic typed = 0, point_t want = '0);
    row_t r;
    r.op = op;
    r.sx = COORD_W'(ax); r.sy = COORD_W'(ay); r.sz = COORD_W'(az);
    r.ex = COORD_W'(bx); r.ey = COORD_W'(by); r.ez = COORD_W'(bz);
    r.tool = tl;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic point_t pt(int x, int y, int z, logic tl, logic lst, logic st, logic ns);
    point_t p;
    p.x = COORD_W'(x); p.y = COORD_W'(y); p.z = COORD_W'(z);
    p.tool = tl; p.last = lst; p.sat = st; p.noseg = ns;
    return p;
  endfunction

  // Offer one item, hold it until the transfer, then idle at random.
  task automatic send(row_t r);
    in_valid  <= 1'b1;
    operation <= r.op;
    sx <= r.sx; sy <= r.sy; sz <= r.sz;
    ex <= r.ex; ey <= r.ey; ez <= r.ez;
    tool_in   <= r.tool;
    has_typed <= r.typed;
    typed_pt  <= r.want;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Write one register and mirror it in the predictor.
  task automatic write_reg(logic [CFG_IDX_W-1:0] i, logic [CFG_W-1:0] v);
    cfg_we   <= 1'b1;
    cfg_idx  <= i;
    cfg_data <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (i == REG_FEED_SPEED) feed = (longint'(v) > SPEED_MAX) ? SPEED_MAX : longint'(v);
    else if (i == REG_INTERVAL_MS) ivl = longint'(v[IVL_W-1:0]);
    else if (i == REG_MIN_LENGTH) minl = longint'(v[MINL_W-1:0]);
  endtask

  // Stop offering, wait out every point and the tail of a trailing load.
  task automatic drain();
    in_valid <= 1'b0;
    while (point_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Random traffic: mostly a load followed by a run of point requests,
  // some stray requests and fully random loads for bit coverage.
  task automatic random_traffic(int span);
    row_t r;
    int   pick, runs, dx, dy, dz;
    int   goal;
    goal = sent + PHASE_ITEMS;
    while (sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        send(row(OP_ADVANCE, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom));
      end else begin
        r = row(OP_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom);
        if (pick >= 15) begin
          dx = $urandom_range(2 * span) - span;
          dy = $urandom_range(2 * span) - span;
          dz = $urandom_range(2 * span) - span;
          if ($urandom_range(3) == 0) dy = 0;
          r.ex = COORD_W'(r.sx + dx);
          r.ey = COORD_W'(r.sy + dy);
          r.ez = COORD_W'(r.sz + dz);
        end
        send(r);
        runs = $urandom_range(14);
        repeat (runs)
          send(row(OP_ADVANCE, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom));
      end
    end
  endtask

  // Receiver: random stalls, plus a long hold when asked for one.
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Predict on every input transfer, check on every output transfer.
  always @(posedge clk_i) begin
    point_t calc, want, got;
    if (rst_ni) begin
      if (in_valid && in_ready_o) begin
        if (operation == OP_LOAD) begin
          take_segment(row(operation, sx, sy, sz, ex, ey, ez, tool_in));
        end else begin
          calc = next_point();
          point_q.push_back(has_typed ? typed_pt : calc);
        end
      end
      if (out_valid_o && out_ready) begin
        got = pt(px, py, pz, tool_out, last_out, sat_out, noseg_out);
        if (point_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("unexpected point transfer x=%0d y=%0d z=%0d", px, py, pz);
        end else begin
          want = point_q.pop_front();
          if (got !== want) begin
            errs++;
            if (errs <= 10)
              $display({"point mismatch: exp x=%0d y=%0d z=%0d t=%b l=%b s=%b n=%b,",
                        " got x=%0d y=%0d z=%0d t=%b l=%b s=%b n=%b"},
                       want.x, want.y, want.z, want.tool, want.last, want.sat,
                       want.noseg, got.x, got.y, got.z, got.tool, got.last,
                       got.sat, got.noseg);
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("linear_segment_interpolator_3d_top regression: fail");
      $finish;
    end
  end

  initial begin
    // directed table: typed rows carry expectations readable at a glance
    plan.push_back(row(OP_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 1, pt(0, 0, 0, 0, 0, 0, 1)));
    // short move: end point only
    plan.push_back(row(OP_LOAD, 0, 0, 0, 10, -5, 3, 1));
    plan.push_back(row(OP_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 1, pt(10, -5, 3, 1, 1, 0, 0)));
    plan.push_back(row(OP_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 1, pt(0, 0, 0, 0, 0, 0, 1)));
    // zero length move
    plan.push_back(row(OP_LOAD, 5, 5, 5, 5, 5, 5, 0));
    plan.push_back(row(OP_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 1, pt(5, 5, 5, 0, 1, 0, 0)));
    // corner to corner: count clamps, first point is the start
    plan.push_back(row(OP_LOAD, -8388608, -8388608, -8388608, 8388607, 8388607, 8388607, 0));
    plan.push_back(row(OP_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 1,
                       pt(-8388608, -8388608, -8388608, 0, 0, 1, 0)));
    plan.push_back(row(OP_ADVANCE, 0, 0, 0, 0, 0, 0, 0));
    // replace mid-segment with a three point move
    plan.push_back(row(OP_LOAD, 100, -200, 50, -80, 40, 301, 1));
    repeat (3) plan.push_back(row(OP_ADVANCE, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(row(OP_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 1, pt(0, 0, 0, 0, 0, 0, 1)));
    // half-way ties round away from zero
    plan.push_back(row(OP_LOAD, 0, 0, 0, -301, 301, -1, 1));
    repeat (3) plan.push_back(row(OP_ADVANCE, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(row(OP_LOAD, 8388607, -8388608, 0, 8388000, -8388000, 7, 0));
    repeat (4) plan.push_back(row(OP_ADVANCE, 0, 0, 0, 0, 0, 0, 0));

    // hold reset at the start, then release once
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle = 31;
    recv_idle = 87;
    foreach (plan[i]) send(plan[i]);
    random_traffic(1000);

    // zero speed and an interval masked down to zero: every count saturates
    drain();
    write_reg(REG_FEED_SPEED, 20'd0);
    write_reg(REG_INTERVAL_MS, 20'h00400);
    write_reg(REG_MIN_LENGTH, 20'd0);
    send_idle = 87;
    recv_idle = 31;
    random_traffic(500);

    // top speed, shortest interval, longest minimum; index past the list
    drain();
    write_reg(REG_FEED_SPEED, 20'hFFFFF);
    write_reg(REG_INTERVAL_MS, 20'd1);
    write_reg(REG_MIN_LENGTH, 20'hFFFF);
    write_reg(REG_UNUSED, 20'h12345);
    send_idle = 0;
    recv_idle = 0;
    hold_cycles = 600;  // block fills up and stalls its input
    random_traffic(100000);

    // one point per unit of length: count lands exactly on the maximum
    drain();
    write_reg(REG_FEED_SPEED, 20'd1);
    write_reg(REG_INTERVAL_MS, 20'd1000);
    write_reg(REG_MIN_LENGTH, 20'd0);
    send(row(OP_LOAD, 0, 0, 0, 65534, 0, 0, 1));
    repeat (3) send(row(OP_ADVANCE, 0, 0, 0, 0, 0, 0, 0));
    random_traffic(8);

    // random mid-range setting
    drain();
    write_reg(REG_FEED_SPEED, CFG_W'($urandom_range(20000, 900000)));
    write_reg(REG_INTERVAL_MS, CFG_W'($urandom_range(1, 1000)));
    write_reg(REG_MIN_LENGTH, CFG_W'($urandom_range(300)));
    random_traffic(3000);

    drain();
    if (errs == 0 && point_q.size() == 0) begin
      $display("linear_segment_interpolator_3d_top regression: pass");
    end else begin
      $display("linear_segment_interpolator_3d_top regression: fail");
    end
    $finish;
  end

endmodule
